// File: src/sacs_pkg.sv
// ----------------------------------------------------------------------------
// Scanned ADC channel smoother package
// Shared widths, defaults, codes and datapath structs.
// ----------------------------------------------------------------------------
package sacs_pkg;

	localparam int NUM_SLOTS_DEF            = 18;
	localparam int ALIGN_SHIFT_DEF          = 19;
	localparam int DEFAULT_FILTER_SHIFT_DEF = 9;
	localparam int DEFAULT_OUT_SHIFT_DEF    = 15;

	localparam int OP_W  = 2;
	localparam int SMP_W = 12;
	localparam int CH_W  = 5;
	localparam int SH_W  = 5;
	localparam int ACC_W = 31;
	localparam int VAL_W = 16;
	localparam int ST_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_READ   = 2'd2
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NO_SLOTS = 2'd2
	} status_t;

	typedef struct packed {
		logic [ACC_W-1:0] accum;
		logic [SMP_W-1:0] sample;
		logic [SH_W-1:0]  filter_shift;
		logic [SH_W-1:0]  out_shift;
	} ema_req_t;

	typedef struct packed {
		logic [ACC_W-1:0] accum;
		logic [VAL_W-1:0] value_upd;
		logic [VAL_W-1:0] value_cur;
	} ema_rsp_t;

endpackage

// File: src/sacs_ema.sv
// ----------------------------------------------------------------------------
// Channel smoother update
// Aligns a sample, applies the shifted error to the accumulator and forms
// the output-shifted read value of the old and the new accumulator.
// ----------------------------------------------------------------------------
module sacs_ema #(
	parameter int ALIGN_SHIFT = sacs_pkg::ALIGN_SHIFT_DEF
) (
	input  sacs_pkg::ema_req_t req,
	output sacs_pkg::ema_rsp_t rsp
);
	import sacs_pkg::*;

	logic [ACC_W-1:0]        aligned;
	logic signed [ACC_W:0]   diff;
	logic signed [ACC_W:0]   step;
	logic [ACC_W:0]          sum;

	always_comb begin
		aligned = ACC_W'({{(ACC_W-SMP_W){1'b0}}, req.sample} << ALIGN_SHIFT);
		diff    = $signed({1'b0, aligned}) - $signed({1'b0, req.accum});
		step    = diff >>> req.filter_shift;
		sum     = {1'b0, req.accum} + $unsigned(step);
		rsp.accum     = sum[ACC_W-1:0];
		rsp.value_upd = VAL_W'(sum[ACC_W-1:0] >> req.out_shift);
		rsp.value_cur = VAL_W'(req.accum >> req.out_shift);
	end

endmodule

// File: src/scanned_adc_channel_smoother.sv
// ----------------------------------------------------------------------------
// Scanned ADC channel smoother
// Multichannel exponential moving average over a round-robin scan list.
//
// Input stream s_*: one command per transfer, kind in s_tuser (append slot,
// sample, read channel). Output stream m_*: exactly one result per command,
// in command order. A command is taken into an input register; the whole
// update (table reads, subtract, shift, add, output shift) is combinational
// from there into the result register, from which the result moves on.
// The block takes one command per cycle while results move on; the
// register tables and the current-slot register carry the state from
// one command to the next without a bubble.
// When the receiver stalls with a result held, one more command is held in
// the input register, and s_tready falls until the result moves on.
// Reset clears the scan list, scan pointer and accumulators, sets every slot
// and channel shift to its default and empties both stream registers.
// ----------------------------------------------------------------------------
module scanned_adc_channel_smoother #(
	parameter int NUM_SLOTS            = sacs_pkg::NUM_SLOTS_DEF,
	parameter int ALIGN_SHIFT          = sacs_pkg::ALIGN_SHIFT_DEF,
	parameter int DEFAULT_FILTER_SHIFT = sacs_pkg::DEFAULT_FILTER_SHIFT_DEF,
	parameter int DEFAULT_OUT_SHIFT    = sacs_pkg::DEFAULT_OUT_SHIFT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// sample[11:0], channel_sel[16:12], filter_shift[21:17], out_shift[26:22]
	input  logic [31:0] s_tdata,
	// opcode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// value[15:0], value_channel[20:16], next_channel[25:21], status[27:26]
	output logic [31:0] m_tdata
);
	import sacs_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	logic [CH_W-1:0]  slot_chan_q [NUM_SLOTS];
	logic [SH_W-1:0]  slot_fsh_q  [NUM_SLOTS];
	logic [SH_W-1:0]  chan_osh_q  [NUM_SLOTS];
	logic [ACC_W-1:0] chan_acc_q  [NUM_SLOTS];
	logic [CNT_W-1:0] slot_cnt_q;
	logic [IDX_W-1:0] scan_ptr_q;
	logic [CH_W-1:0]  cur_chan_q;
	logic [SH_W-1:0]  cur_fsh_q;

	logic             valid_s1;
	logic [OP_W-1:0]  op_s1;
	logic [SMP_W-1:0] smp_s1;
	logic [CH_W-1:0]  ch_s1;
	logic [SH_W-1:0]  fsh_s1;
	logic [SH_W-1:0]  osh_s1;

	logic             out_valid_q;
	logic [31:0]      out_data_q;

	logic             adv;
	logic             fire;
	logic             ch_ok;
	logic [IDX_W-1:0] ch_idx;
	logic [IDX_W-1:0] acc_idx;
	logic [CNT_W-1:0] ptr_inc;
	logic [IDX_W-1:0] nsp_idx;
	logic             do_append;
	logic             do_sample;
	logic [CNT_W-1:0] cnt_d;
	logic [IDX_W-1:0] ptr_d;
	logic [CH_W-1:0]  cur_chan_d;
	logic [SH_W-1:0]  cur_fsh_d;
	logic [VAL_W-1:0] res_value;
	logic [CH_W-1:0]  res_vch;
	logic [CH_W-1:0]  res_next;
	status_t          res_status;
	ema_req_t         ema_req;
	ema_rsp_t         ema_rsp;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign ch_ok   = {1'b0, ch_s1} < (CH_W+1)'(NUM_SLOTS);
	assign ch_idx  = ch_s1[IDX_W-1:0];
	assign acc_idx = (op_s1 == OP_SAMPLE) ? cur_chan_q[IDX_W-1:0] : ch_idx;
	assign ptr_inc = CNT_W'(scan_ptr_q) + CNT_W'(1);
	assign nsp_idx = (ptr_inc >= slot_cnt_q) ? '0 : ptr_inc[IDX_W-1:0];

	assign ema_req.accum        = chan_acc_q[acc_idx];
	assign ema_req.sample       = smp_s1;
	assign ema_req.filter_shift = cur_fsh_q;
	assign ema_req.out_shift    = chan_osh_q[acc_idx];

	sacs_ema #(
		.ALIGN_SHIFT(ALIGN_SHIFT)
	) u_ema (
		.req(ema_req),
		.rsp(ema_rsp)
	);

	always_comb begin
		do_append  = 1'b0;
		do_sample  = 1'b0;
		cnt_d      = slot_cnt_q;
		ptr_d      = scan_ptr_q;
		cur_chan_d = cur_chan_q;
		cur_fsh_d  = cur_fsh_q;
		res_value  = '0;
		res_vch    = '0;
		res_status = ST_OK;
		case (op_s1)
			OP_APPEND: begin
				if (slot_cnt_q >= CNT_W'(NUM_SLOTS)) begin
					res_status = ST_FULL;
				end else if (ch_ok) begin
					do_append = 1'b1;
					cnt_d     = slot_cnt_q + CNT_W'(1);
					if (slot_cnt_q == '0) begin
						cur_chan_d = ch_s1;
						cur_fsh_d  = fsh_s1;
					end
				end
			end
			OP_SAMPLE: begin
				if (slot_cnt_q == '0) begin
					res_status = ST_NO_SLOTS;
				end else begin
					do_sample  = 1'b1;
					res_value  = ema_rsp.value_upd;
					res_vch    = cur_chan_q;
					ptr_d      = nsp_idx;
					cur_chan_d = slot_chan_q[nsp_idx];
					cur_fsh_d  = slot_fsh_q[nsp_idx];
				end
			end
			OP_READ: begin
				res_value = ch_ok ? ema_rsp.value_cur : '0;
				res_vch   = ch_s1;
			end
			default: begin
			end
		endcase
		res_next = (cnt_d != '0) ? cur_chan_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1  <= s_tuser;
			smp_s1 <= s_tdata[11:0];
			ch_s1  <= s_tdata[16:12];
			fsh_s1 <= s_tdata[21:17];
			osh_s1 <= s_tdata[26:22];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_chan_q[i] <= '0;
				slot_fsh_q[i]  <= SH_W'(DEFAULT_FILTER_SHIFT);
				chan_osh_q[i]  <= SH_W'(DEFAULT_OUT_SHIFT);
				chan_acc_q[i]  <= '0;
			end
			slot_cnt_q <= '0;
			scan_ptr_q <= '0;
			cur_chan_q <= '0;
			cur_fsh_q  <= SH_W'(DEFAULT_FILTER_SHIFT);
		end else if (fire) begin
			if (do_append) begin
				slot_chan_q[slot_cnt_q[IDX_W-1:0]] <= ch_s1;
				slot_fsh_q[slot_cnt_q[IDX_W-1:0]]  <= fsh_s1;
				chan_osh_q[ch_idx]                 <= osh_s1;
			end
			if (do_sample) begin
				chan_acc_q[acc_idx] <= ema_rsp.accum;
			end
			slot_cnt_q <= cnt_d;
			scan_ptr_q <= ptr_d;
			cur_chan_q <= cur_chan_d;
			cur_fsh_q  <= cur_fsh_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {4'b0, res_status, res_next, res_vch, res_value};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_cnt_q <= CNT_W'(NUM_SLOTS))
		else $error("slot count above list size");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_cnt_q != '0) |-> (CNT_W'(scan_ptr_q) < slot_cnt_q))
		else $error("scan pointer outside scan list");

	a_ptr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_cnt_q == '0) |-> (scan_ptr_q == '0))
		else $error("scan pointer moved with empty list");

	a_cur_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_cnt_q != '0) |-> (cur_chan_q == slot_chan_q[scan_ptr_q]
			&& cur_fsh_q == slot_fsh_q[scan_ptr_q]))
		else $error("current slot register out of step with table");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("result lost after update");

	a_noslot_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op_s1 == OP_SAMPLE && slot_cnt_q == '0) |=>
			($stable(slot_cnt_q) && $stable(scan_ptr_q)))
		else $error("sample without slots changed scan state");

endmodule
